/* src/first_fit_block_allocator_defines.svh */
// Assertion macros for the allocator's RTL files; ffba_dpath uses them.
// Files that check their own logic include this header; it depends on nothing.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define FFBA_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// A condition that must be followed by a consequence in the next cycle.
`define FFBA_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/ffba_pkg.sv */
// Shared constants, table entry type, controller states and the command and
// status groups that join the controller to the datapath. No dependencies.
package ffba_pkg;

  localparam int MAX_BLOCKS   = 64;
  localparam int HEADER_BYTES = 32;
  localparam int IDX_W        = $clog2(MAX_BLOCKS);
  // Pointers reach one past the entry count, which itself reaches MAX_BLOCKS.
  localparam int CNT_W        = $clog2(MAX_BLOCKS + 2);
  localparam int TYPE_W       = 2;
  localparam int BYTE_W       = 21;
  localparam int NEED_W       = BYTE_W + 1;
  localparam int USED_W       = 7;

  localparam logic [BYTE_W-1:0] ARENA_RESET = 21'd65536;

  // Request codes.
  localparam logic [TYPE_W-1:0] REQ_ALLOC = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_FREE  = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_INFO  = 2'd2;

  typedef struct packed {
    logic              used;
    logic [BYTE_W-1:0] request;
    logic [BYTE_W-1:0] start;
  } entry_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_PUT_NEW,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic init;
    logic scan;
    logic shift;
    logic put_new;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic bad_type;
    logic scan_done;
    logic do_shift;
    logic copy_done;
    logic put_new;
    logic res_free;
  } status_t;

endpackage

/* src/ffba_req_if.sv */
// Request channel of the allocator: valid, ready and the request fields.
// Depends on ffba_pkg for field widths.
interface ffba_req_if;
  import ffba_pkg::*;

  logic              valid;
  logic              ready;
  logic [TYPE_W-1:0] req_type;
  logic [BYTE_W-1:0] req_size;
  logic [BYTE_W-1:0] req_offset;

  modport source (output valid, req_type, req_size, req_offset, input ready);
  modport sink (input valid, req_type, req_size, req_offset, output ready);
endinterface

/* src/ffba_res_if.sv */
// Result channel of the allocator: valid, ready and the result fields.
// Depends on ffba_pkg for field widths.
interface ffba_res_if;
  import ffba_pkg::*;

  logic              valid;
  logic              ready;
  logic              ok;
  logic [BYTE_W-1:0] data_offset;
  logic [USED_W-1:0] used_blocks;
  logic [BYTE_W-1:0] allocated_bytes;
  logic [BYTE_W-1:0] largest_free;

  modport source (output valid, ok, data_offset, used_blocks, allocated_bytes,
                  largest_free, input ready);
  modport sink (input valid, ok, data_offset, used_blocks, allocated_bytes,
                largest_free, output ready);
endinterface

/* src/ffba_ctrl.sv */
// Controller state machine of the allocator: sequences table init, scan,
// entry shifting and result hand-off. Depends on ffba_pkg.
module ffba_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             in_valid,
  output logic             in_ready,
  input  ffba_pkg::status_t st,
  output ffba_pkg::cmd_t    cmd
);
  import ffba_pkg::*;

  state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT: begin
        state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (cfg_we) begin
          state_next = ST_INIT;
        end else if (in_valid) begin
          state_next = st.bad_type ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (st.scan_done) begin
          state_next = st.do_shift ? ST_SHIFT : ST_FINISH;
        end
      end
      ST_SHIFT: begin
        if (st.copy_done) begin
          state_next = st.put_new ? ST_PUT_NEW : ST_FINISH;
        end
      end
      ST_PUT_NEW: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (st.res_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    in_ready    = (state == ST_IDLE) && !cfg_we;
    cmd         = '0;
    cmd.load    = in_ready && in_valid;
    cmd.init    = (state == ST_INIT);
    cmd.scan    = (state == ST_SCAN);
    cmd.shift   = (state == ST_SHIFT);
    cmd.put_new = (state == ST_PUT_NEW);
    cmd.finish  = (state == ST_FINISH) && st.res_free;
  end

endmodule

/* src/ffba_dpath.sv */
// Datapath of the allocator: block table memory, scan evaluation, entry
// copy engine and result register. Depends on ffba_pkg and the defines header.
`include "first_fit_block_allocator_defines.svh"

module ffba_dpath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [ffba_pkg::BYTE_W-1:0]   cfg_wdata,
  input  logic [ffba_pkg::TYPE_W-1:0]   req_type,
  input  logic [ffba_pkg::BYTE_W-1:0]   req_size,
  input  logic [ffba_pkg::BYTE_W-1:0]   req_offset,
  input  logic                          res_ready,
  output logic                          res_valid,
  output logic                          ok,
  output logic [ffba_pkg::BYTE_W-1:0]   data_offset,
  output logic [ffba_pkg::USED_W-1:0]   used_blocks,
  output logic [ffba_pkg::BYTE_W-1:0]   allocated_bytes,
  output logic [ffba_pkg::BYTE_W-1:0]   largest_free,
  input  ffba_pkg::cmd_t                cmd,
  output ffba_pkg::status_t             st
);
  import ffba_pkg::*;

  localparam logic [NEED_W-1:0] HDR_N = NEED_W'(HEADER_BYTES);
  localparam logic [BYTE_W-1:0] HDR_B = BYTE_W'(HEADER_BYTES);
  localparam logic [CNT_W-1:0]  MAX_C = CNT_W'(MAX_BLOCKS);
  localparam logic [CNT_W-1:0]  ONE_C = CNT_W'(1);
  localparam logic [CNT_W-1:0]  TWO_C = CNT_W'(2);

  entry_t mem [MAX_BLOCKS];
  entry_t rdata;
  entry_t p;

  logic [BYTE_W-1:0] arena;
  logic [CNT_W-1:0]  count;
  logic [TYPE_W-1:0] op;
  logic [BYTE_W-1:0] size;
  logic [BYTE_W-1:0] off;
  logic [NEED_W-1:0] need;
  logic [CNT_W-1:0]  ptr;
  logic [CNT_W-1:0]  aidx;
  logic [CNT_W-1:0]  cp_left;
  logic              av;
  logic              pv;
  logic              dir_up;
  logic              amt2;
  logic              found;
  logic              prevfree;
  logic [CNT_W-1:0]  fi;
  logic              put_flag;
  logic [CNT_W-1:0]  new_idx;
  logic [BYTE_W-1:0] new_start;
  logic [USED_W-1:0] acc_used;
  logic [BYTE_W-1:0] acc_alloc;
  logic [BYTE_W-1:0] acc_large;
  logic              pend_ok;
  logic [BYTE_W-1:0] pend_off;
  logic [USED_W-1:0] pend_used;
  logic [BYTE_W-1:0] pend_alloc;
  logic [BYTE_W-1:0] pend_large;

  logic [IDX_W-1:0]  rd_addr;
  logic              we;
  logic [IDX_W-1:0]  wa;
  entry_t            wd;
  logic              scan_arr;
  logic              at_end;
  logic [BYTE_W-1:0] end_v;
  logic [BYTE_W-1:0] span;
  logic [NEED_W-1:0] span_x;
  logic [BYTE_W-1:0] pay;
  logic              evalb;
  logic              alloc_hit;
  logic              split;
  logic              alloc_fail;
  logic              free_match;
  logic              free_fail;
  logic              free_dec;
  logic              next_free;
  logic              info_done;
  logic [CNT_W-1:0]  hit_idx;
  logic [USED_W-1:0] used_n;
  logic [BYTE_W-1:0] alloc_n;
  logic [BYTE_W-1:0] large_n;

  // Evaluation of the entry pair at the read port. Block p ends where the
  // arriving entry starts, or at the arena end for the virtual entry past the
  // table.
  always_comb begin
    rd_addr    = ptr[IDX_W-1:0];
    scan_arr   = cmd.scan && av;
    at_end     = (aidx == count);
    end_v      = at_end ? arena : rdata.start;
    span       = (end_v > p.start) ? (end_v - p.start) : '0;
    span_x     = {1'b0, span};
    pay        = (span > HDR_B) ? (span - HDR_B) : '0;
    evalb      = scan_arr && pv;
    hit_idx    = aidx - ONE_C;
    alloc_hit  = evalb && (op == REQ_ALLOC) && !p.used && (span_x >= need);
    split      = alloc_hit && ((span_x - need) >= HDR_N) && (count < MAX_C);
    alloc_fail = scan_arr && (op == REQ_ALLOC) && at_end && !alloc_hit;
    free_match = scan_arr && (op == REQ_FREE) && !found && !at_end &&
                 (({1'b0, rdata.start} + HDR_N) == {1'b0, off});
    free_fail  = scan_arr && (op == REQ_FREE) && !found &&
                 (at_end || (free_match && !rdata.used));
    free_dec   = scan_arr && (op == REQ_FREE) && found;
    next_free  = !at_end && !rdata.used;
    info_done  = scan_arr && (op == REQ_INFO) && at_end;
    used_n     = acc_used + USED_W'(p.used);
    alloc_n    = acc_alloc + (p.used ? p.request : '0);
    large_n    = (!p.used && (pay > acc_large)) ? pay : acc_large;
  end

  // Status to the controller.
  always_comb begin
    st           = '0;
    st.bad_type  = (req_type != REQ_ALLOC) && (req_type != REQ_FREE) &&
                   (req_type != REQ_INFO);
    st.scan_done = alloc_hit || alloc_fail || free_dec || free_fail || info_done;
    st.do_shift  = split || (free_dec && (prevfree || next_free));
    st.copy_done = (cp_left == '0) && !av;
    st.put_new   = put_flag;
    st.res_free  = !res_valid || res_ready;
  end

  // Table write port, one write per cycle.
  always_comb begin
    we = 1'b0;
    wa = '0;
    wd = '0;
    priority if (cmd.init) begin
      we = 1'b1;
    end else if (alloc_hit) begin
      we = 1'b1;
      wa = hit_idx[IDX_W-1:0];
      wd = entry_t'{used: 1'b1, request: size, start: p.start};
    end else if (free_dec && !prevfree) begin
      we = 1'b1;
      wa = fi[IDX_W-1:0];
      wd = entry_t'{used: 1'b0, request: p.request, start: p.start};
    end else if (cmd.shift && av) begin
      we = 1'b1;
      wa = aidx[IDX_W-1:0];
      wd = rdata;
    end else if (cmd.put_new) begin
      we = 1'b1;
      wa = new_idx[IDX_W-1:0];
      wd = entry_t'{used: 1'b0, request: '0, start: new_start};
    end
  end

  // Block table memory with registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[rd_addr];
  end

  // Scan, decision and copy sequencing.
  always_ff @(posedge clk) begin
    if (rst) begin
      arena     <= ARENA_RESET;
      count     <= ONE_C;
      av        <= 1'b0;
      pv        <= 1'b0;
      found     <= 1'b0;
      put_flag  <= 1'b0;
      cp_left   <= '0;
      res_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        arena <= cfg_wdata;
        count <= ONE_C;
      end

      if (cmd.load) begin
        op         <= req_type;
        size       <= req_size;
        off        <= req_offset;
        need       <= {1'b0, req_size} + HDR_N;
        ptr        <= '0;
        av         <= 1'b0;
        pv         <= 1'b0;
        found      <= 1'b0;
        put_flag   <= 1'b0;
        cp_left    <= '0;
        acc_used   <= '0;
        acc_alloc  <= '0;
        acc_large  <= '0;
        pend_ok    <= 1'b0;
        pend_off   <= '0;
        pend_used  <= '0;
        pend_alloc <= '0;
        pend_large <= '0;
      end else if (cmd.scan) begin
        if (st.scan_done) begin
          av <= 1'b0;
          if (alloc_hit) begin
            pend_ok  <= 1'b1;
            pend_off <= p.start + HDR_B;
            if (split) begin
              ptr       <= count - ONE_C;
              cp_left   <= count - aidx;
              dir_up    <= 1'b1;
              new_idx   <= aidx;
              new_start <= p.start + need[BYTE_W-1:0];
              put_flag  <= 1'b1;
              count     <= count + ONE_C;
            end
          end else if (free_dec) begin
            pend_ok <= 1'b1;
            if (prevfree && next_free) begin
              // Both neighbors free: drop this block and the next one.
              ptr     <= fi + TWO_C;
              cp_left <= count - fi - TWO_C;
              dir_up  <= 1'b0;
              amt2    <= 1'b1;
              count   <= count - TWO_C;
            end else if (next_free) begin
              ptr     <= fi + TWO_C;
              cp_left <= count - fi - TWO_C;
              dir_up  <= 1'b0;
              amt2    <= 1'b0;
              count   <= count - ONE_C;
            end else if (prevfree) begin
              ptr     <= fi + ONE_C;
              cp_left <= count - fi - ONE_C;
              dir_up  <= 1'b0;
              amt2    <= 1'b0;
              count   <= count - ONE_C;
            end
          end else if (info_done) begin
            pend_ok    <= 1'b1;
            pend_used  <= used_n;
            pend_alloc <= alloc_n;
            pend_large <= large_n;
          end
        end else begin
          av   <= (ptr <= count);
          aidx <= ptr;
          if (ptr <= count) begin
            ptr <= ptr + ONE_C;
          end
          if (scan_arr) begin
            p  <= rdata;
            pv <= 1'b1;
          end
          if (evalb && (op == REQ_INFO)) begin
            acc_used  <= used_n;
            acc_alloc <= alloc_n;
            acc_large <= large_n;
          end
          if (free_match && rdata.used) begin
            found    <= 1'b1;
            fi       <= aidx;
            prevfree <= pv && !p.used;
          end
        end
      end else if (cmd.shift) begin
        // Stream entries up one slot, or down one or two; the write lands in the cycle after the read.
        av <= (cp_left != '0);
        if (cp_left != '0) begin
          ptr     <= dir_up ? (ptr - ONE_C) : (ptr + ONE_C);
          cp_left <= cp_left - ONE_C;
          aidx    <= dir_up ? (ptr + ONE_C) : (ptr - (amt2 ? TWO_C : ONE_C));
        end
      end else begin
        av <= 1'b0;
      end

      // Result register.
      if (cmd.finish) begin
        res_valid       <= 1'b1;
        ok              <= pend_ok;
        data_offset     <= pend_off;
        used_blocks     <= pend_used;
        allocated_bytes <= pend_alloc;
        largest_free    <= pend_large;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  `FFBA_CHECK(a_count_range, (count != '0) && (count <= MAX_C), "entry count out of range")
  `FFBA_CHECK(a_one_outcome, $onehot0({alloc_hit, alloc_fail, free_dec, free_fail, info_done}), "several scan outcomes at once")
  `FFBA_CHECK(a_copy_in_table, (cmd.shift && av) |-> (aidx < count), "copy lands outside the table")
  `FFBA_NEXT(a_split_grows, split, count == $past(count) + ONE_C, "split did not add an entry")

endmodule

/* src/first_fit_block_allocator.sv */
// Top level of the first-fit block allocator: controller plus datapath.
// Depends on ffba_pkg, ffba_req_if, ffba_res_if, ffba_ctrl and ffba_dpath.
//
//   Channel   Direction  Handshake       Contents
//   req       in         valid / ready   req_type, req_size, req_offset
//   res       out        valid / ready   ok, data_offset, used_blocks,
//                                        allocated_bytes, largest_free
//   cfg       in         cfg_we          cfg_wdata (arena size in bytes)
//
// One request is worked at a time; the table walk reads one entry a cycle from
// the block table memory. A merge or a split adds a shift of the later entries
// to the walk. After reset or a cfg_we write the block writes the first table
// entry in its init state before taking requests.
// A finished result waits in the output register; a new request is taken
// while it waits, and its own result is held until the old one is taken.
module first_fit_block_allocator (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [ffba_pkg::BYTE_W-1:0] cfg_wdata,
  ffba_req_if.sink                    req,
  ffba_res_if.source                  res
);
  import ffba_pkg::*;

  cmd_t    cmd;
  status_t st;
  logic    in_ready;

  assign req.ready = in_ready;

  // Controller.
  ffba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // Datapath.
  ffba_dpath u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .req_type        (req.req_type),
    .req_size        (req.req_size),
    .req_offset      (req.req_offset),
    .res_ready       (res.ready),
    .res_valid       (res.valid),
    .ok              (res.ok),
    .data_offset     (res.data_offset),
    .used_blocks     (res.used_blocks),
    .allocated_bytes (res.allocated_bytes),
    .largest_free    (res.largest_free),
    .cmd             (cmd),
    .st              (st)
  );

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for first_fit_block_allocator: a directed table, then random
// allocation traffic, checked against a behavioral model or, on fixed rows, hand-written results.
// Depends on ffba_pkg, ffba_req_if, ffba_res_if and the allocator RTL.
module tb;
  import ffba_pkg::*;

  typedef struct packed {
    logic              ok;
    logic [BYTE_W-1:0] data_offset;
    logic [USED_W-1:0] used_blocks;
    logic [BYTE_W-1:0] allocated_bytes;
    logic [BYTE_W-1:0] largest_free;
  } alloc_result_t;

  typedef struct {
    logic [TYPE_W-1:0] kind;
    logic [BYTE_W-1:0] size;
    logic [BYTE_W-1:0] offset;
    bit                fixed;
    alloc_result_t     want;
  } stim_row_t;

  localparam logic [TYPE_W-1:0] REQ_BAD = 2'd3;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 2 * MAX_BLOCKS + 40;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [BYTE_W-1:0] cfg_wdata;

  ffba_req_if req_ch ();
  ffba_res_if res_ch ();

  first_fit_block_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .res       (res_ch)
  );

  // Model of the block table.
  int unsigned   arena_size;
  int unsigned   blk_start [MAX_BLOCKS];
  bit            blk_used [MAX_BLOCKS];
  int unsigned   blk_req [MAX_BLOCKS];
  int unsigned   blk_count;

  alloc_result_t pending_results [$];
  logic [BYTE_W-1:0] live_offsets [$];
  int            fail_count;
  int            idle_cycles;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void table_clear();
    for (int k = 0; k < MAX_BLOCKS; k++) begin
      blk_start[k] = 0;
      blk_used[k] = 1'b0;
      blk_req[k] = 0;
    end
    blk_count = 1;
  endfunction

  function automatic int unsigned span_at(int unsigned i);
    int unsigned stop;
    stop = (i + 1 < blk_count) ? blk_start[i + 1] : arena_size;
    return (stop > blk_start[i]) ? stop - blk_start[i] : 0;
  endfunction

  function automatic void drop_entry(int unsigned i);
    for (int unsigned k = i; k + 1 < blk_count; k++) begin
      blk_start[k] = blk_start[k + 1];
      blk_used[k] = blk_used[k + 1];
      blk_req[k] = blk_req[k + 1];
    end
    blk_count--;
  endfunction

  function automatic void add_free_entry(int unsigned i, int unsigned at);
    for (int unsigned k = blk_count; k > i; k--) begin
      blk_start[k] = blk_start[k - 1];
      blk_used[k] = blk_used[k - 1];
      blk_req[k] = blk_req[k - 1];
    end
    blk_start[i] = at;
    blk_used[i] = 1'b0;
    blk_req[i] = 0;
    blk_count++;
  endfunction

  // Applies one request to the model table and returns its result.
  function automatic alloc_result_t apply_request(logic [TYPE_W-1:0] kind,
                                                  logic [BYTE_W-1:0] size,
                                                  logic [BYTE_W-1:0] offset);
    alloc_result_t r;
    int unsigned need, sp, i, used_n, bytes_n, big, pay;
    r = '0;
    if (kind == REQ_ALLOC) begin
      need = 32'(size) + HEADER_BYTES;
      for (i = 0; i < blk_count; i++) begin
        sp = span_at(i);
        if (!blk_used[i] && sp >= need) begin
          if (sp - need >= HEADER_BYTES && blk_count < MAX_BLOCKS)
            add_free_entry(i + 1, blk_start[i] + need);
          blk_used[i] = 1'b1;
          blk_req[i] = 32'(size);
          r.ok = 1'b1;
          r.data_offset = BYTE_W'(blk_start[i] + HEADER_BYTES);
          break;
        end
      end
    end else if (kind == REQ_FREE) begin
      for (i = 0; i < blk_count; i++)
        if (blk_start[i] + HEADER_BYTES == 32'(offset)) break;
      if (i < blk_count && blk_used[i]) begin
        blk_used[i] = 1'b0;
        if (i + 1 < blk_count && !blk_used[i + 1]) drop_entry(i + 1);
        if (i > 0 && !blk_used[i - 1]) drop_entry(i);
        r.ok = 1'b1;
      end
    end else if (kind == REQ_INFO) begin
      used_n = 0;
      bytes_n = 0;
      big = 0;
      for (i = 0; i < blk_count; i++) begin
        if (blk_used[i]) begin
          used_n++;
          bytes_n += blk_req[i];
        end else begin
          sp = span_at(i);
          pay = (sp > HEADER_BYTES) ? sp - HEADER_BYTES : 0;
          if (pay > big) big = pay;
        end
      end
      r.ok = 1'b1;
      r.used_blocks = USED_W'(used_n);
      r.allocated_bytes = BYTE_W'(bytes_n);
      r.largest_free = BYTE_W'(big);
    end
    return r;
  endfunction

  // Gap length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  // Drives one request and waits for its handshake; the model is updated on acceptance.
  task automatic send_request(logic [TYPE_W-1:0] kind, logic [BYTE_W-1:0] size,
                              logic [BYTE_W-1:0] offset, bit fixed, alloc_result_t want);
    alloc_result_t got;
    int gap;
    req_ch.valid <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.req_size <= size;
    req_ch.req_offset <= offset;
    do @(posedge clk); while (!req_ch.ready);
    got = apply_request(kind, size, offset);
    if (kind == REQ_ALLOC && got.ok) live_offsets.push_back(got.data_offset);
    pending_results.push_back(fixed ? want : got);
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Rewrites the arena size once the block has drained; the table restarts empty.
  task automatic set_arena(logic [BYTE_W-1:0] bytes);
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= bytes;
    @(posedge clk);
    cfg_we <= 1'b0;
    arena_size = 32'(bytes);
    table_clear();
    live_offsets.delete();
    repeat (4) @(posedge clk);
  endtask

  // One random request, biased toward frees of live blocks so the table fills and drains.
  task automatic random_request();
    int roll, pick;
    logic [TYPE_W-1:0] kind;
    logic [BYTE_W-1:0] size, offset;
    roll = $urandom_range(0, 99);
    size = BYTE_W'($urandom);
    offset = BYTE_W'($urandom);
    if (roll < 55) begin
      kind = REQ_ALLOC;
      pick = $urandom_range(0, 99);
      if (pick < 70) size = BYTE_W'($urandom_range(0, arena_size / 80 + 1));
      else if (pick < 90) size = BYTE_W'($urandom_range(0, arena_size));
    end else if (roll < 85) begin
      kind = REQ_FREE;
      pick = $urandom_range(0, 99);
      if (pick < 75 && live_offsets.size() != 0) begin
        pick = $urandom_range(0, live_offsets.size() - 1);
        offset = live_offsets[pick];
        live_offsets.delete(pick);
      end else if (pick < 88 && live_offsets.size() != 0) begin
        offset = BYTE_W'(live_offsets[$urandom_range(0, live_offsets.size() - 1)]
                         + $urandom_range(0, 2) - 1);
      end
    end else if (roll < 98) begin
      kind = REQ_INFO;
    end else begin
      kind = REQ_BAD;
    end
    send_request(kind, size, offset, 1'b0, '0);
  endtask

  // Result side: random back-pressure and a field-by-field check of each result.
  initial begin
    alloc_result_t want;
    int stall;
    res_ch.ready <= 1'b0;
    stall = 0;
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid && res_ch.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result ok=%0b", $time, res_ch.ok);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (res_ch.ok !== want.ok) begin
            $display("%0t: ok expected %0b actual %0b", $time, want.ok, res_ch.ok);
            fail_count++;
          end
          if (res_ch.data_offset !== want.data_offset) begin
            $display("%0t: data_offset expected %0d actual %0d", $time,
                     want.data_offset, res_ch.data_offset);
            fail_count++;
          end
          if (res_ch.used_blocks !== want.used_blocks) begin
            $display("%0t: used_blocks expected %0d actual %0d", $time,
                     want.used_blocks, res_ch.used_blocks);
            fail_count++;
          end
          if (res_ch.allocated_bytes !== want.allocated_bytes) begin
            $display("%0t: allocated_bytes expected %0d actual %0d", $time,
                     want.allocated_bytes, res_ch.allocated_bytes);
            fail_count++;
          end
          if (res_ch.largest_free !== want.largest_free) begin
            $display("%0t: largest_free expected %0d actual %0d", $time,
                     want.largest_free, res_ch.largest_free);
            fail_count++;
          end
        end
      end
      if (rst) begin
        res_ch.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        res_ch.ready <= 1'b0;
      end else begin
        stall = pick_gap();
        res_ch.ready <= (stall == 0);
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a request or result.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired", $time);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Stimulus.
  initial begin
    stim_row_t rows [$];
    stim_row_t row;
    logic [BYTE_W-1:0] arenas [6];
    fail_count = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_INFO;
    req_ch.req_size = '0;
    req_ch.req_offset = '0;
    arena_size = 32'(ARENA_RESET);
    table_clear();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    repeat (3) @(posedge clk);

    // Directed table; rows with fixed set carry a hand-written result.
    row = '{REQ_INFO, 0, 0, 1, '{1'b1, 0, 0, 0, 21'd65504}};       rows.push_back(row);
    row = '{REQ_ALLOC, 21'd1048576, 0, 1, '0};                     rows.push_back(row);
    row = '{REQ_ALLOC, 21'h1FFFFF, 0, 1, '0};                      rows.push_back(row);
    row = '{REQ_FREE, 0, 21'd32, 1, '0};                           rows.push_back(row);
    row = '{REQ_FREE, 0, 0, 1, '0};                                rows.push_back(row);
    row = '{REQ_BAD, 21'h1FFFFF, 21'h1FFFFF, 1, '0};               rows.push_back(row);
    row = '{REQ_ALLOC, 0, 0, 1, '{1'b1, 21'd32, 0, 0, 0}};         rows.push_back(row);
    row = '{REQ_ALLOC, 21'd100, 0, 0, '0};                         rows.push_back(row);
    row = '{REQ_ALLOC, 21'd7, 0, 0, '0};                           rows.push_back(row);
    row = '{REQ_INFO, 0, 0, 0, '0};                                rows.push_back(row);
    row = '{REQ_FREE, 0, 21'd64, 0, '0};                           rows.push_back(row);
    row = '{REQ_FREE, 0, 21'd64, 0, '0};                           rows.push_back(row);
    row = '{REQ_FREE, 0, 21'd65, 0, '0};                           rows.push_back(row);
    row = '{REQ_FREE, 0, 21'd32, 0, '0};                           rows.push_back(row);
    row = '{REQ_INFO, 0, 0, 0, '0};                                rows.push_back(row);
    row = '{REQ_ALLOC, 21'd65504, 0, 0, '0};                       rows.push_back(row);
    row = '{REQ_INFO, 0, 0, 0, '0};                                rows.push_back(row);
    row = '{REQ_FREE, 0, 21'd32, 0, '0};                           rows.push_back(row);
    row = '{REQ_ALLOC, 21'd65505, 0, 0, '0};                       rows.push_back(row);
    row = '{REQ_INFO, 0, 0, 0, '0};                                rows.push_back(row);
    foreach (rows[n])
      send_request(rows[n].kind, rows[n].size, rows[n].offset, rows[n].fixed,
                   rows[n].want);

    // Random phases across arena sizes, the extremes among them.
    arenas[0] = 21'd64;
    arenas[1] = 21'd1048576;
    arenas[2] = 21'd1048575;
    arenas[3] = 21'd100;
    arenas[4] = BYTE_W'($urandom_range(64, 1048576));
    arenas[5] = ARENA_RESET;
    foreach (arenas[p]) begin
      set_arena(arenas[p]);
      repeat (215) random_request();
    end

    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/ffba_pkg.sv
src/ffba_req_if.sv
src/ffba_res_if.sv
src/ffba_ctrl.sv
src/ffba_dpath.sv
src/first_fit_block_allocator.sv
tb/sv/tb.sv
